// File: src/lafq12_pkg.sv
// Shared constants and types for the Q12 LPC analysis filter.
`default_nettype none
package lafq12_pkg;

   localparam int unsigned SAMPLE_W     = 16;
   localparam int unsigned COEF_W       = 16;
   localparam int unsigned ACC_W        = 32;
   localparam int unsigned ORDER_W      = 5;
   localparam int unsigned Q_SHIFT      = 12;
   localparam int unsigned MIN_ORDER    = 6;
   localparam int unsigned COEF_REGS    = 4;
   localparam int unsigned TAPS_PER_REG = 4;
   localparam int unsigned CSR_DATA_W   = COEF_W * TAPS_PER_REG;
   localparam int unsigned CSR_INDEX_W  = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FILTER_ORDER = 3'd0,
      CSR_COEF_0_TO_3  = 3'd1,
      CSR_COEF_4_TO_7  = 3'd2,
      CSR_COEF_8_TO_11 = 3'd3,
      CSR_COEF_12_TO_15 = 3'd4
   } csr_index_type;

   typedef logic [CSR_DATA_W-1:0]      coef_reg_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ACC_W-1:0]    acc_type;

endpackage
`default_nettype wire

// File: src/lpc_analysis_fir_q12.sv
// LPC analysis filter: one sample in per transaction, one residual out in sample units (Q0).
//
// Each accepted sample produces one residual: sample * 4096 minus the sum of the
// last filter_order samples of the frame times their signed Q12 taps (tap 0 is the
// newest past sample), wrapped to 32 bits, rounded right by 12 and saturated to
// 16 bits. The first filter_order results of a frame are zero with primed low; a
// sample with the frame-start flag restarts the history. A new sample is taken
// every cycle while the output is not stalled; a result passes two register stages,
// one holding the parallel tap products and one holding the summed, rounded residual.
// Write configuration only while no transaction is in flight.
`default_nettype none
module lpc_analysis_fir_q12 #(
   parameter int unsigned MAX_ORDER = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [lafq12_pkg::SAMPLE_W-1:0]        req_tdata,  // [15:0] sample
   input  wire logic                                   req_tuser,  // [0] frame_start
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [lafq12_pkg::SAMPLE_W-1:0]             rsp_tdata,  // [15:0] residual
   output logic                                        rsp_tuser,  // [0] primed
   input  wire logic                                   csr_we,
   input  wire logic [lafq12_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [lafq12_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned SEEN_W = $clog2(MAX_ORDER + 1);

   // configuration
   logic [lafq12_pkg::ORDER_W-1:0] order_ff;
   lafq12_pkg::coef_reg_type       coef_ff [lafq12_pkg::COEF_REGS];
   logic                           order_ok;

   // frame history
   lafq12_pkg::sample_type         hist_ff [MAX_ORDER];
   logic [SEEN_W-1:0]              seen_ff;
   logic [SEEN_W-1:0]              seen_base;
   logic [SEEN_W-1:0]              seen_in;
   logic                           primed_in;

   // product stage
   logic                           s1_valid_ff;
   lafq12_pkg::acc_type            s1_prod_ff [MAX_ORDER];
   lafq12_pkg::acc_type            s1_prod_in [MAX_ORDER];
   lafq12_pkg::sample_type         s1_sample_ff;
   logic                           s1_primed_ff;

   // result stage
   logic                           rsp_valid_ff;
   logic [lafq12_pkg::SAMPLE_W-1:0] rsp_residual_ff;
   logic [lafq12_pkg::SAMPLE_W-1:0] rsp_residual_in;
   logic                           rsp_primed_ff;

   logic                           accept;
   logic                           out_adv;
   logic                           s1_adv;

   lafq12_pkg::acc_type            sum_tree [1:2*MAX_ORDER-1];
   lafq12_pkg::acc_type            acc_sum;
   lafq12_pkg::acc_type            diff;
   logic signed [lafq12_pkg::ACC_W:0] rounded_sum;
   logic signed [lafq12_pkg::ACC_W-lafq12_pkg::Q_SHIFT:0] shifted;

   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_adv;
   assign req_tready = !s1_valid_ff || out_adv;
   assign accept     = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_residual_ff;
   assign rsp_tuser  = rsp_primed_ff;

   // ---------------- configuration writes ----------------
   assign order_ok = (csr_wdata >= lafq12_pkg::CSR_DATA_W'(lafq12_pkg::MIN_ORDER))
                  && (csr_wdata <= lafq12_pkg::CSR_DATA_W'(MAX_ORDER))
                  && !csr_wdata[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= lafq12_pkg::ORDER_W'(MAX_ORDER);
         for (int i = 0; i < lafq12_pkg::COEF_REGS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            lafq12_pkg::CSR_FILTER_ORDER: begin
               if (order_ok) begin
                  order_ff <= csr_wdata[lafq12_pkg::ORDER_W-1:0];
               end
            end
            lafq12_pkg::CSR_COEF_0_TO_3:   coef_ff[0] <= csr_wdata;
            lafq12_pkg::CSR_COEF_4_TO_7:   coef_ff[1] <= csr_wdata;
            lafq12_pkg::CSR_COEF_8_TO_11:  coef_ff[2] <= csr_wdata;
            lafq12_pkg::CSR_COEF_12_TO_15: coef_ff[3] <= csr_wdata;
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // ---------------- history and warm-up count ----------------
   always_comb begin
      seen_base = req_tuser ? '0 : seen_ff;
      primed_in = lafq12_pkg::ORDER_W'(seen_base) >= order_ff;
      seen_in   = (seen_base < SEEN_W'(MAX_ORDER)) ? seen_base + SEEN_W'(1) : seen_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         for (int k = 0; k < MAX_ORDER; k++) begin
            hist_ff[k] <= '0;
         end
      end else if (accept) begin
         seen_ff <= seen_in;
         // shift in the new sample; a frame start clears the older entries
         hist_ff[0] <= lafq12_pkg::sample_type'(req_tdata);
         for (int k = 1; k < MAX_ORDER; k++) begin
            hist_ff[k] <= req_tuser ? '0 : hist_ff[k-1];
         end
      end
   end

   // ---------------- tap products ----------------
   for (genvar k = 0; k < MAX_ORDER; k++) begin : g_tap
      localparam int unsigned REG_SEL = k / lafq12_pkg::TAPS_PER_REG;
      localparam int unsigned LO_BIT  = (k % lafq12_pkg::TAPS_PER_REG) * lafq12_pkg::COEF_W;
      logic signed [lafq12_pkg::COEF_W-1:0] coef;
      logic                                 used;
      logic signed [lafq12_pkg::ACC_W-1:0]  prod;

      assign coef = coef_ff[REG_SEL][LO_BIT +: lafq12_pkg::COEF_W];
      assign used = lafq12_pkg::ORDER_W'(k) < order_ff;
      assign prod = hist_ff[k] * coef;

      assign s1_prod_in[k] = (used && !req_tuser) ? prod : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= lafq12_pkg::sample_type'(req_tdata);
         s1_primed_ff <= primed_in;
         for (int k = 0; k < MAX_ORDER; k++) begin
            s1_prod_ff[k] <= s1_prod_in[k];
         end
      end
   end

   // ---------------- sum, round, saturate ----------------
   always_comb begin
      // balanced adder tree: leaves at the upper half, root at index 1
      for (int k = 0; k < MAX_ORDER; k++) begin
         sum_tree[MAX_ORDER + k] = s1_prod_ff[k];
      end
      for (int i = MAX_ORDER - 1; i > 0; i--) begin
         sum_tree[i] = sum_tree[2 * i] + sum_tree[2 * i + 1];
      end
      acc_sum = sum_tree[1];
      diff = lafq12_pkg::ACC_W'({{(lafq12_pkg::ACC_W-lafq12_pkg::SAMPLE_W-
                                  lafq12_pkg::Q_SHIFT){s1_sample_ff[lafq12_pkg::SAMPLE_W-1]}},
                                 s1_sample_ff, {lafq12_pkg::Q_SHIFT{1'b0}}}) - acc_sum;
      rounded_sum = {diff[lafq12_pkg::ACC_W-1], diff}
                  + (lafq12_pkg::ACC_W+1)'(1 << (lafq12_pkg::Q_SHIFT - 1));
      shifted = rounded_sum[lafq12_pkg::ACC_W:lafq12_pkg::Q_SHIFT];
      priority if (!s1_primed_ff) begin
         rsp_residual_in = '0;
      end else if (shifted > $signed((lafq12_pkg::ACC_W-lafq12_pkg::Q_SHIFT+1)'(32767))) begin
         rsp_residual_in = 16'h7FFF;
      end else if (shifted < -$signed((lafq12_pkg::ACC_W-lafq12_pkg::Q_SHIFT+1)'(32768))) begin
         rsp_residual_in = 16'h8000;
      end else begin
         rsp_residual_in = shifted[lafq12_pkg::SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_residual_ff <= rsp_residual_in;
         rsp_primed_ff   <= s1_primed_ff;
      end
   end

endmodule
`default_nettype wire
